>>> design/ctsf_pkg.sv
`timescale 1ns / 1ps

package ctsf_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int NODE_COUNT  = 10;
  localparam int VERTEX_CNT  = 3;
  localparam int IN_W        = 18;
  localparam int OUT_W       = 24;
  localparam int NODE_W      = 4;

  // barycentric coordinate: |L0| <= 2^FRAC_BITS + 2^IN_W
  localparam int LW   = ((FRAC_BITS > IN_W) ? FRAC_BITS : IN_W) + 2;
  // first-level operands (3L - 2, 6L - 1, ...)
  localparam int OW   = LW + 3;
  localparam int PR1W = 2 * OW;
  localparam int P1W  = PR1W - FRAC_BITS;
  localparam int PR2W = P1W + LW;
  localparam int P3W  = PR2W - FRAC_BITS;
  // second-level values and gradient sums share one width
  localparam int PW   = (P3W > P1W + 6) ? P3W : P1W + 6;
  // after the final constant scale (at most x27)
  localparam int SW   = PW + 5;

  typedef enum logic [1:0] {
    KIND_VERTEX,
    KIND_EDGE,
    KIND_CENTROID
  } node_kind_t;

  typedef enum logic [1:0] {
    SGN_NEG,
    SGN_ZERO,
    SGN_POS
  } sgn_t;

  function automatic node_kind_t kind_of(input logic [NODE_W-1:0] node);
    node_kind_t k;
    if (node < NODE_W'(VERTEX_CNT)) begin
      k = KIND_VERTEX;
    end else if (node < NODE_W'(NODE_COUNT - 1)) begin
      k = KIND_EDGE;
    end else begin
      k = KIND_CENTROID;
    end
    return k;
  endfunction

  // first barycentric index of an edge node
  function automatic logic [1:0] edge_a(input logic [NODE_W-1:0] node);
    logic [NODE_W-1:0] e;
    logic [1:0]        r;
    e = node - NODE_W'(VERTEX_CNT);
    unique case (e)
      4'd0:    r = 2'd0;
      4'd1:    r = 2'd1;
      4'd2:    r = 2'd1;
      4'd3:    r = 2'd2;
      4'd4:    r = 2'd2;
      4'd5:    r = 2'd0;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // second barycentric index of an edge node
  function automatic logic [1:0] edge_b(input logic [NODE_W-1:0] node);
    logic [NODE_W-1:0] e;
    logic [1:0]        r;
    e = node - NODE_W'(VERTEX_CNT);
    unique case (e)
      4'd0:    r = 2'd1;
      4'd1:    r = 2'd0;
      4'd2:    r = 2'd2;
      4'd3:    r = 2'd1;
      4'd4:    r = 2'd0;
      4'd5:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // dLi/dxi
  function automatic sgn_t dxi_sgn(input logic [1:0] idx);
    sgn_t s;
    unique case (idx)
      2'd0:    s = SGN_NEG;
      2'd1:    s = SGN_POS;
      2'd2:    s = SGN_ZERO;
      default: s = SGN_ZERO;
    endcase
    return s;
  endfunction

  // dLi/deta
  function automatic sgn_t deta_sgn(input logic [1:0] idx);
    sgn_t s;
    unique case (idx)
      2'd0:    s = SGN_NEG;
      2'd1:    s = SGN_ZERO;
      2'd2:    s = SGN_POS;
      default: s = SGN_ZERO;
    endcase
    return s;
  endfunction

  function automatic logic signed [PW-1:0] apply_sgn(input logic signed [PW-1:0] x,
                                                     input sgn_t s);
    logic signed [PW-1:0] r;
    unique case (s)
      SGN_NEG: r = -x;
      SGN_POS: r = x;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> design/ctsf_if.sv
`timescale 1ns / 1ps

interface ctsf_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ctsf_pkg::IN_W-1:0]     xi;
  logic signed [ctsf_pkg::IN_W-1:0]     eta;

  modport source (output valid, output xi, output eta, input ready);
  modport sink   (input valid, input xi, input eta, output ready);
endinterface

interface ctsf_out_if;
  logic                                 valid;
  logic                                 ready;
  logic        [ctsf_pkg::NODE_W-1:0]   node;
  logic signed [ctsf_pkg::OUT_W-1:0]    value;
  logic signed [ctsf_pkg::OUT_W-1:0]    d_dxi;
  logic signed [ctsf_pkg::OUT_W-1:0]    d_deta;
  logic                                 last;

  modport source (output valid, output node, output value, output d_dxi, output d_deta,
                  output last, input ready);
  modport sink   (input valid, input node, input value, input d_dxi, input d_deta,
                  input last, output ready);
endinterface

>>> design/cubic_triangle_shape_functions.sv
`timescale 1ns / 1ps
// channel   dir   word                                                  handshake
// in_ch     in    xi, eta: s18 Q2.16                                    valid / ready
// out_ch    out   node u4, value / d_dxi / d_deta s24 Q8.16 sat, last   valid / ready
//
// The node sequencer issues one node per cycle, unless a stalled output word freezes it,
// into a seven-register pipeline, and the output channel takes one node word per cycle
// while out_ready is high. A point is held in the point register while its nodes are issued;
// the next point is taken in the cycle its predecessor's last node is issued.
// rst_n (synchronous, active low) clears the sequencer and all valid bits.
// A word held at the output with out_ready low freezes the whole pipeline and drops
// in_ready; nothing is lost.

module cubic_triangle_shape_functions (
  input  logic        clk,
  input  logic        rst_n,
  ctsf_in_if.sink     in_ch,
  ctsf_out_if.source  out_ch
);

  localparam int FB    = ctsf_pkg::FRAC_BITS;
  localparam int NW    = ctsf_pkg::NODE_W;
  localparam int LW    = ctsf_pkg::LW;
  localparam int OW    = ctsf_pkg::OW;
  localparam int PR1W  = ctsf_pkg::PR1W;
  localparam int P1W   = ctsf_pkg::P1W;
  localparam int PR2W  = ctsf_pkg::PR2W;
  localparam int PW    = ctsf_pkg::PW;
  localparam int SW    = ctsf_pkg::SW;
  localparam int OUTW  = ctsf_pkg::OUT_W;

  localparam logic [NW-1:0]          NODE_LAST = NW'(ctsf_pkg::NODE_COUNT - 1);
  localparam logic signed [LW-1:0]   ONE_L     = LW'(1) << FB;
  localparam logic signed [OW-1:0]   ONE_O     = OW'(1) << FB;
  localparam logic signed [OW-1:0]   TWO_O     = OW'(2) << FB;
  localparam logic signed [PW-1:0]   TWO_P     = PW'(2) << FB;
  localparam logic [PR1W-1:0]        RND1      = PR1W'(1) << (FB - 1);
  localparam logic [PR2W-1:0]        RND2      = PR2W'(1) << (FB - 1);
  localparam logic [SW-1:0]          POS_LIM   = SW'((1 << (OUTW - 1)) - 1);
  localparam logic [SW-1:0]          NEG_LIM   = SW'(1) << (OUTW - 1);
  localparam logic signed [OUTW-1:0] OUT_MAX   = {1'b0, {(OUTW - 1){1'b1}}};
  localparam logic signed [OUTW-1:0] OUT_MIN   = {1'b1, {(OUTW - 1){1'b0}}};

  typedef struct {
    logic [NW-1:0]          node;
    logic signed [OW-1:0]   x [3];
    logic signed [OW-1:0]   y [3];
    logic signed [LW-1:0]   z;
  } ops_t;

  typedef struct {
    logic [NW-1:0]          node;
    logic signed [PR1W-1:0] pr [3];
    logic signed [LW-1:0]   z;
  } prod1_t;

  typedef struct {
    logic [NW-1:0]          node;
    logic signed [P1W-1:0]  p [3];
    logic signed [LW-1:0]   z;
  } lvl1_t;

  typedef struct {
    logic [NW-1:0]          node;
    logic signed [PR2W-1:0] pr3;
    logic signed [PW-1:0]   pre_x;
    logic signed [PW-1:0]   pre_y;
  } prod2_t;

  // value, d_dxi, d_deta in sign / magnitude form
  typedef struct {
    logic [NW-1:0]          node;
    logic                   neg [3];
    logic [PW-1:0]          mag [3];
  } lvl2_t;

  typedef struct {
    logic [NW-1:0]          node;
    logic                   neg [3];
    logic [SW-1:0]          mag [3];
  } scl_t;

  logic                   en;
  logic                   in_ready;
  logic                   in_acc;
  logic                   issue;

  logic signed [LW-1:0]   l_r [3];
  logic signed [LW-1:0]   l_nxt [3];
  logic                   pt_valid_r, pt_valid_nxt;
  logic [NW-1:0]          cnt_r, cnt_nxt;

  ops_t                   ops_r, ops_nxt;
  prod1_t                 prod1_r, prod1_nxt;
  lvl1_t                  lvl1_r, lvl1_nxt;
  prod2_t                 prod2_r, prod2_nxt;
  lvl2_t                  lvl2_r, lvl2_nxt;
  scl_t                   scl_r, scl_nxt;
  logic                   ops_v_r, prod1_v_r, lvl1_v_r, prod2_v_r, lvl2_v_r, scl_v_r;

  logic                   out_valid_r;
  logic [NW-1:0]          out_node_r, out_node_nxt;
  logic signed [OUTW-1:0] out_val_r [3];
  logic signed [OUTW-1:0] out_val_nxt [3];
  logic                   out_last_r, out_last_nxt;

  // whole pipeline moves unless a finished word is stuck at the output
  assign en       = !out_valid_r || out_ch.ready;
  assign in_ready = en && (!pt_valid_r || cnt_r == NODE_LAST);
  assign in_acc   = in_ch.valid && in_ready;
  assign issue    = en && pt_valid_r;

  assign in_ch.ready = in_ready;

  // ---------------- point register and node sequencer ----------------
  always_comb begin
    logic signed [LW-1:0] xe;
    logic signed [LW-1:0] ee;
    xe = LW'(in_ch.xi);
    ee = LW'(in_ch.eta);
    l_nxt[0] = ONE_L - xe - ee;
    l_nxt[1] = xe;
    l_nxt[2] = ee;

    pt_valid_nxt = pt_valid_r;
    cnt_nxt      = cnt_r;
    if (in_acc) begin
      pt_valid_nxt = 1'b1;
      cnt_nxt      = '0;
    end else if (issue) begin
      if (cnt_r == NODE_LAST) begin
        pt_valid_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_valid_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      pt_valid_r <= pt_valid_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      l_r <= l_nxt;
    end
  end

  // ---------------- operand select ----------------
  function automatic logic signed [LW-1:0] sel_l(input logic [1:0] idx,
                                                 input logic signed [LW-1:0] l0,
                                                 input logic signed [LW-1:0] l1,
                                                 input logic signed [LW-1:0] l2);
    logic signed [LW-1:0] r;
    unique case (idx)
      2'd0:    r = l0;
      2'd1:    r = l1;
      default: r = l2;
    endcase
    return r;
  endfunction

  always_comb begin
    ctsf_pkg::node_kind_t kind;
    logic signed [LW-1:0] lv, la, lb;
    logic signed [OW-1:0] lvo, lao, lbo, three_v, three_a, six_a;
    kind    = ctsf_pkg::kind_of(cnt_r);
    lv      = sel_l(cnt_r[1:0], l_r[0], l_r[1], l_r[2]);
    la      = sel_l(ctsf_pkg::edge_a(cnt_r), l_r[0], l_r[1], l_r[2]);
    lb      = sel_l(ctsf_pkg::edge_b(cnt_r), l_r[0], l_r[1], l_r[2]);
    lvo     = OW'(lv);
    lao     = OW'(la);
    lbo     = OW'(lb);
    three_v = (lvo <<< 1) + lvo;
    three_a = (lao <<< 1) + lao;
    six_a   = three_a <<< 1;

    ops_nxt.node = cnt_r;
    ops_nxt.x[2] = '0;
    ops_nxt.y[2] = '0;
    unique case (kind)
      ctsf_pkg::KIND_VERTEX: begin
        ops_nxt.x[0] = three_v - ONE_O;
        ops_nxt.y[0] = three_v - TWO_O;
        ops_nxt.x[1] = lvo;
        ops_nxt.y[1] = lvo;
        ops_nxt.z    = lv;
      end
      ctsf_pkg::KIND_EDGE: begin
        ops_nxt.x[0] = lbo;
        ops_nxt.y[0] = six_a - ONE_O;
        ops_nxt.x[1] = lao;
        ops_nxt.y[1] = three_a - ONE_O;
        ops_nxt.z    = lb;
      end
      default: begin
        ops_nxt.x[0] = OW'(l_r[0]);
        ops_nxt.y[0] = OW'(l_r[1]);
        ops_nxt.x[1] = OW'(l_r[0]);
        ops_nxt.y[1] = OW'(l_r[2]);
        ops_nxt.x[2] = OW'(l_r[1]);
        ops_nxt.y[2] = OW'(l_r[2]);
        ops_nxt.z    = l_r[2];
      end
    endcase
  end

  // ---------------- first-level products ----------------
  always_comb begin
    prod1_nxt.node = ops_r.node;
    prod1_nxt.z    = ops_r.z;
    for (int k = 0; k < 3; k++) begin
      prod1_nxt.pr[k] = PR1W'(ops_r.x[k]) * PR1W'(ops_r.y[k]);
    end
  end

  // round half away from zero, drop fraction bits
  always_comb begin
    logic          neg1;
    logic [PR1W-1:0] mag1;
    logic [PR1W-1:0] rnd1;
    lvl1_nxt.node = prod1_r.node;
    lvl1_nxt.z    = prod1_r.z;
    for (int k = 0; k < 3; k++) begin
      neg1 = prod1_r.pr[k][PR1W-1];
      mag1 = neg1 ? PR1W'(-prod1_r.pr[k]) : PR1W'(prod1_r.pr[k]);
      rnd1 = (mag1 + RND1) >> FB;
      lvl1_nxt.p[k] = neg1 ? P1W'(-rnd1) : P1W'(rnd1);
    end
  end

  // ---------------- second-level product and gradient sums ----------------
  always_comb begin
    ctsf_pkg::node_kind_t kind;
    logic signed [P1W-1:0] m2a;
    logic signed [PW-1:0]  p0, p1, p2, ze, s;
    logic [1:0]            ia, ib;
    kind = ctsf_pkg::kind_of(lvl1_r.node);
    m2a  = (kind == ctsf_pkg::KIND_EDGE) ? lvl1_r.p[1] : lvl1_r.p[0];
    p0   = PW'(lvl1_r.p[0]);
    p1   = PW'(lvl1_r.p[1]);
    p2   = PW'(lvl1_r.p[2]);
    ze   = PW'(lvl1_r.z);
    ia   = ctsf_pkg::edge_a(lvl1_r.node);
    ib   = ctsf_pkg::edge_b(lvl1_r.node);
    // vertex gradient numerator: 27 L^2 - 18 L + 2
    s    = (p1 <<< 4) + (p1 <<< 3) + (p1 <<< 1) + p1 - ((ze <<< 4) + (ze <<< 1)) + TWO_P;

    prod2_nxt.node = lvl1_r.node;
    prod2_nxt.pr3  = PR2W'(m2a) * PR2W'(lvl1_r.z);
    unique case (kind)
      ctsf_pkg::KIND_VERTEX: begin
        prod2_nxt.pre_x = ctsf_pkg::apply_sgn(s, ctsf_pkg::dxi_sgn(lvl1_r.node[1:0]));
        prod2_nxt.pre_y = ctsf_pkg::apply_sgn(s, ctsf_pkg::deta_sgn(lvl1_r.node[1:0]));
      end
      ctsf_pkg::KIND_EDGE: begin
        prod2_nxt.pre_x = ctsf_pkg::apply_sgn(p0, ctsf_pkg::dxi_sgn(ia))
                        + ctsf_pkg::apply_sgn(p1, ctsf_pkg::dxi_sgn(ib));
        prod2_nxt.pre_y = ctsf_pkg::apply_sgn(p0, ctsf_pkg::deta_sgn(ia))
                        + ctsf_pkg::apply_sgn(p1, ctsf_pkg::deta_sgn(ib));
      end
      default: begin
        prod2_nxt.pre_x = p1 - p2;
        prod2_nxt.pre_y = p0 - p2;
      end
    endcase
  end

  // round the second product; turn everything into sign / magnitude
  always_comb begin
    logic            neg3;
    logic [PR2W-1:0] mag3;
    logic [PR2W-1:0] rnd3;
    neg3 = prod2_r.pr3[PR2W-1];
    mag3 = neg3 ? PR2W'(-prod2_r.pr3) : PR2W'(prod2_r.pr3);
    rnd3 = (mag3 + RND2) >> FB;

    lvl2_nxt.node   = prod2_r.node;
    lvl2_nxt.neg[0] = neg3;
    lvl2_nxt.mag[0] = PW'(rnd3);
    lvl2_nxt.neg[1] = prod2_r.pre_x[PW-1];
    lvl2_nxt.mag[1] = prod2_r.pre_x[PW-1] ? PW'(-prod2_r.pre_x) : PW'(prod2_r.pre_x);
    lvl2_nxt.neg[2] = prod2_r.pre_y[PW-1];
    lvl2_nxt.mag[2] = prod2_r.pre_y[PW-1] ? PW'(-prod2_r.pre_y) : PW'(prod2_r.pre_y);
  end

  // ---------------- constant scale: x1/2, x9/2 or x27 ----------------
  always_comb begin
    ctsf_pkg::node_kind_t kind;
    logic [SW-1:0] m;
    kind         = ctsf_pkg::kind_of(lvl2_r.node);
    scl_nxt.node = lvl2_r.node;
    for (int k = 0; k < 3; k++) begin
      m              = SW'(lvl2_r.mag[k]);
      scl_nxt.neg[k] = lvl2_r.neg[k];
      unique case (kind)
        ctsf_pkg::KIND_VERTEX: scl_nxt.mag[k] = (m + SW'(1)) >> 1;
        ctsf_pkg::KIND_EDGE:   scl_nxt.mag[k] = ((m << 3) + m + SW'(1)) >> 1;
        default:               scl_nxt.mag[k] = (m << 4) + (m << 3) + (m << 1) + m;
      endcase
    end
  end

  // ---------------- sign and saturate to the output format ----------------
  always_comb begin
    out_node_nxt = scl_r.node;
    out_last_nxt = (scl_r.node == NODE_LAST);
    for (int k = 0; k < 3; k++) begin
      if (scl_r.neg[k]) begin
        out_val_nxt[k] = (scl_r.mag[k] > NEG_LIM) ? OUT_MIN : OUTW'(-scl_r.mag[k]);
      end else begin
        out_val_nxt[k] = (scl_r.mag[k] > POS_LIM) ? OUT_MAX : OUTW'(scl_r.mag[k]);
      end
    end
  end

  // ---------------- pipeline registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ops_v_r     <= 1'b0;
      prod1_v_r   <= 1'b0;
      lvl1_v_r    <= 1'b0;
      prod2_v_r   <= 1'b0;
      lvl2_v_r    <= 1'b0;
      scl_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      ops_v_r     <= issue;
      prod1_v_r   <= ops_v_r;
      lvl1_v_r    <= prod1_v_r;
      prod2_v_r   <= lvl1_v_r;
      lvl2_v_r    <= prod2_v_r;
      scl_v_r     <= lvl2_v_r;
      out_valid_r <= scl_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ops_r      <= ops_nxt;
      prod1_r    <= prod1_nxt;
      lvl1_r     <= lvl1_nxt;
      prod2_r    <= prod2_nxt;
      lvl2_r     <= lvl2_nxt;
      scl_r      <= scl_nxt;
      out_node_r <= out_node_nxt;
      out_val_r  <= out_val_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.node   = out_node_r;
  assign out_ch.value  = out_val_r[0];
  assign out_ch.d_dxi  = out_val_r[1];
  assign out_ch.d_deta = out_val_r[2];
  assign out_ch.last   = out_last_r;

endmodule

>>> design/ctsf_checker.sv
`timescale 1ns / 1ps

module ctsf_checker (
  input  logic        clk,
  input  logic        rst_n,
  ctsf_in_if.sink     in_ch,
  ctsf_out_if.source  out_ch
);

  localparam int            NW        = ctsf_pkg::NODE_W;
  localparam logic [NW-1:0] NODE_LAST = NW'(ctsf_pkg::NODE_COUNT - 1);

  logic          in_acc, out_acc;
  logic [NW-1:0] exp_r, exp_nxt;
  logic [2:0]    pending_r, pending_nxt;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  // points taken whose node 9 word has not gone out yet
  always_comb begin
    pending_nxt = pending_r;
    if (in_acc && !(out_acc && out_ch.last)) begin
      pending_nxt = pending_r + 3'd1;
    end else if (!in_acc && out_acc && out_ch.last) begin
      pending_nxt = pending_r - 3'd1;
    end
    exp_nxt = exp_r;
    if (out_acc) begin
      exp_nxt = out_ch.last ? '0 : exp_r + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      exp_r     <= '0;
    end else begin
      pending_r <= pending_nxt;
      exp_r     <= exp_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.node)
      && $stable(out_ch.value) && $stable(out_ch.d_dxi) && $stable(out_ch.d_deta)
      && $stable(out_ch.last))
    else $error("result word changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  a_point_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("second point taken before the first was issued");

  a_node_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.node == exp_r) && (out_ch.last == (exp_r == NODE_LAST)))
    else $error("node words out of order or last misplaced");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> pending_r != 3'd0)
    else $error("result word without a point in flight");

endmodule

bind cubic_triangle_shape_functions ctsf_checker u_ctsf_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
